[src/bfd_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the box filter downsampler
// no dependencies; imported by bfd_engine and box_filter_downsample

package bfd_pkg;

  localparam int REG_W   = 9;
  localparam int COORD_W = 8;
  localparam int CH_W    = 16;
  localparam int NUM_CH  = 4;
  localparam int PROD_W  = COORD_W + REG_W;
  localparam int CNT_W   = 2 * REG_W;
  localparam int SUM_W   = CH_W + CNT_W;

  localparam int SIDE_LIMIT = 256;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 9'd256;
  localparam logic [REG_W-1:0] SIDE_RESET   = 9'd128;

  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_OUT_SIDE   = 2'd2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // channel 0 is red, then green, blue, alpha
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
    logic [REG_W-1:0] side;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    pixel_t             pix;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DSTART,
    S_DWAIT,
    S_COUNT,
    S_READ,
    S_DRAIN,
    S_CSTART,
    S_CWAIT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_BW,
    OP_BH,
    OP_QX,
    OP_QY,
    OP_SX,
    OP_SY
  } setup_op_t;

endpackage

[src/bfd_divider.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters

module bfd_divider #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] count;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[src/bfd_engine.sv]
`timescale 1ns / 1ps
// pixel store and box averaging sequencer
// depends on bfd_pkg and bfd_divider

module bfd_engine import bfd_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               opcode,
  input  logic [COORD_W-1:0] src_x,
  input  logic [COORD_W-1:0] src_y,
  input  pixel_t             in_pix,
  input  logic [COORD_W-1:0] want_x,
  input  logic [COORD_W-1:0] want_y,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  localparam int XW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = 2 * XW;

  state_t state, state_next;
  setup_op_t step;

  pixel_t mem [2**AW];
  pixel_t rd_data;
  logic   rd_pend;
  logic   mem_we;
  logic   rd_en;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  logic [COORD_W-1:0] wx, wy;
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic [PROD_W-1:0]  qx, qy;
  logic [REG_W-1:0]   bw, bh, sx, sy;
  logic [REG_W-1:0]   i, j, px, py;
  logic [CNT_W-1:0]   n;
  logic [SUM_W-1:0]   sum [NUM_CH];

  logic               setup_start, setup_busy, setup_done;
  logic [PROD_W-1:0]  setup_num, setup_quo;
  logic [REG_W-1:0]   setup_den, setup_rem;
  logic [REG_W-1:0]   quo_low;

  logic               ch_start;
  logic [NUM_CH-1:0]  ch_done;
  logic [NUM_CH-1:0]  ch_busy;
  logic [SUM_W-1:0]   ch_quo [NUM_CH];
  logic [CNT_W-1:0]   ch_rem [NUM_CH];

  logic last_col, last_row;
  logic [REG_W-1:0] px_inc, py_inc;

  assign last_col = (i + REG_W'(1)) == bw;
  assign last_row = (j + REG_W'(1)) == bh;
  assign px_inc   = px + REG_W'(1);
  assign py_inc   = py + REG_W'(1);
  assign quo_low  = setup_quo[REG_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (item_valid && opcode == OP_COMPUTE) state_next = S_MUL;
      S_MUL:    state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT:  if (setup_done) state_next = (step == OP_SY) ? S_COUNT : S_DSTART;
      S_COUNT:  state_next = S_READ;
      S_READ:   if (last_col && last_row) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_CSTART;
      S_CSTART: state_next = S_CWAIT;
      S_CWAIT:  if (ch_done[0]) state_next = S_OUT;
      S_OUT:    if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    item_ready  = state == S_IDLE;
    res_valid   = state == S_OUT;
    setup_start = state == S_DSTART;
    ch_start    = state == S_CSTART;
    rd_en       = state == S_READ;
    mem_we      = (state == S_IDLE) && item_valid && (opcode == OP_LOAD)
                  && (int'(src_x) < MAX_DIM) && (int'(src_y) < MAX_DIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
    end
  end

  assign waddr = {XW'(src_y), XW'(src_x)};
  assign raddr = {XW'(py), XW'(px)};

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= in_pix;
    if (rd_en) rd_data <= mem[raddr];
  end

  // operand select for the shared setup divider
  always_comb begin
    setup_num = PROD_W'(cfg.width);
    setup_den = cfg.side;
    case (step)
      OP_BW: begin setup_num = PROD_W'(cfg.width);  setup_den = cfg.side;   end
      OP_BH: begin setup_num = PROD_W'(cfg.height); setup_den = cfg.side;   end
      OP_QX: begin setup_num = prod_x;              setup_den = cfg.side;   end
      OP_QY: begin setup_num = prod_y;              setup_den = cfg.side;   end
      OP_SX: begin setup_num = qx;                  setup_den = cfg.width;  end
      OP_SY: begin setup_num = qy;                  setup_den = cfg.height; end
      default: begin setup_num = '0;                setup_den = cfg.side;   end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        wx <= want_x;
        wy <= want_y;
      end
      S_MUL: begin
        prod_x <= PROD_W'(wx) * PROD_W'(cfg.width);
        prod_y <= PROD_W'(wy) * PROD_W'(cfg.height);
        step   <= OP_BW;
      end
      S_DWAIT: begin
        if (setup_done) begin
          case (step)
            OP_BW: begin
              bw   <= (quo_low == '0) ? REG_W'(1) : quo_low;
              step <= OP_BH;
            end
            OP_BH: begin
              bh   <= (quo_low == '0) ? REG_W'(1) : quo_low;
              step <= OP_QX;
            end
            OP_QX: begin
              qx   <= setup_quo;
              step <= OP_QY;
            end
            OP_QY: begin
              qy   <= setup_quo;
              step <= OP_SX;
            end
            OP_SX: begin
              sx   <= setup_rem;
              step <= OP_SY;
            end
            default: sy <= setup_rem;
          endcase
        end
      end
      S_COUNT: begin
        n  <= CNT_W'(bw) * CNT_W'(bh);
        i  <= '0;
        j  <= '0;
        px <= sx;
        py <= sy;
      end
      S_READ: begin
        if (last_col) begin
          i  <= '0;
          px <= sx;
          j  <= j + REG_W'(1);
          py <= (py_inc == cfg.height) ? '0 : py_inc;
        end else begin
          i  <= i + REG_W'(1);
          px <= (px_inc == cfg.width) ? '0 : px_inc;
        end
      end
      default: ;
    endcase
  end

  // channel sums, one pixel per cycle behind the read
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (state == S_COUNT) begin
        sum[c] <= '0;
      end else if (rd_pend) begin
        sum[c] <= sum[c] + SUM_W'(rd_data[c]);
      end
    end
  end

  bfd_divider #(
    .NUM_W (PROD_W),
    .DEN_W (REG_W)
  ) u_setup_div (
    .clk       (clk),
    .rst       (rst),
    .start     (setup_start),
    .dividend  (setup_num),
    .divisor   (setup_den),
    .busy      (setup_busy),
    .done      (setup_done),
    .quotient  (setup_quo),
    .remainder (setup_rem)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    bfd_divider #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
    ) u_ch_div (
      .clk       (clk),
      .rst       (rst),
      .start     (ch_start),
      .dividend  (sum[c]),
      .divisor   (n),
      .busy      (ch_busy[c]),
      .done      (ch_done[c]),
      .quotient  (ch_quo[c]),
      .remainder (ch_rem[c])
    );
    assign res.pix[c] = ch_quo[c][CH_W-1:0];
  end

  assign res.x = wx;
  assign res.y = wy;

  a_box_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> (i < bw) && (j < bh))
    else $error("box counter outside box");

  a_src_wrap: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> (px < cfg.width) && (py < cfg.height))
    else $error("source coordinate not wrapped");

  a_setup_start_idle: assert property (@(posedge clk) disable iff (rst)
    setup_start |-> !setup_busy)
    else $error("setup divider restarted while busy");

  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    ch_done[0] |-> (ch_done == {NUM_CH{1'b1}}) && (ch_busy == '0))
    else $error("channel dividers out of step");

  a_res_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result dropped before transfer");

endmodule

[src/box_filter_downsample.sv]
`timescale 1ns / 1ps
// Box filter downsampler: stores a source image of 16-bit RGBA pixels and
// returns the truncated box average for each requested output pixel. A load
// item is written to the pixel store as it is accepted. For a compute item
// with a box of bw*bh pixels, six serial divisions of 17 bits set up the
// box origin and size, the pixel store is read one pixel per cycle over the
// box, and four 34-bit serial dividers form the averages in parallel. Items
// are taken one at a time; a finished result sits in the output register
// while the next item is accepted. Reading a pixel that was never loaded
// gives undefined channel values.

module box_filter_downsample import bfd_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [REG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [COORD_W-1:0] src_x,
  input  logic [COORD_W-1:0] src_y,
  input  logic [CH_W-1:0]    in_red,
  input  logic [CH_W-1:0]    in_green,
  input  logic [CH_W-1:0]    in_blue,
  input  logic [CH_W-1:0]    in_alpha,
  input  logic [COORD_W-1:0] want_x,
  input  logic [COORD_W-1:0] want_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] res_x,
  output logic [COORD_W-1:0] res_y,
  output logic [CH_W-1:0]    out_red,
  output logic [CH_W-1:0]    out_green,
  output logic [CH_W-1:0]    out_blue,
  output logic [CH_W-1:0]    out_alpha
);

  logic [REG_W-1:0] src_width, src_height, out_side;
  cfg_t    cfg;
  pixel_t  in_pix;
  result_t eng_res;
  result_t res_q;
  logic    eng_valid;
  logic    eng_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= WIDTH_RESET;
      src_height <= HEIGHT_RESET;
      out_side   <= SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data;
        CFG_SRC_HEIGHT: src_height <= cfg_data;
        CFG_OUT_SIDE:   out_side   <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize reads as the limit
  always_comb begin
    cfg.width  = (src_width == '0) ? REG_W'(1) :
                 (int'(src_width) > MAX_DIM) ? REG_W'(MAX_DIM) : src_width;
    cfg.height = (src_height == '0) ? REG_W'(1) :
                 (int'(src_height) > MAX_DIM) ? REG_W'(MAX_DIM) : src_height;
    cfg.side   = (out_side == '0) ? REG_W'(1) :
                 (int'(out_side) > SIDE_LIMIT) ? REG_W'(SIDE_LIMIT) : out_side;
  end

  assign in_pix = {in_alpha, in_blue, in_green, in_red};

  bfd_engine #(
    .MAX_DIM (MAX_DIM)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .opcode     (opcode),
    .src_x      (src_x),
    .src_y      (src_y),
    .in_pix     (in_pix),
    .want_x     (want_x),
    .want_y     (want_y),
    .res_valid  (eng_valid),
    .res_ready  (eng_take),
    .res        (eng_res)
  );

  // output register frees the engine once the result is handed over
  assign eng_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_valid && eng_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_valid && eng_take) res_q <= eng_res;
  end

  assign res_x     = res_q.x;
  assign res_y     = res_q.y;
  assign out_red   = res_q.pix[0];
  assign out_green = res_q.pix[1];
  assign out_blue  = res_q.pix[2];
  assign out_alpha = res_q.pix[3];

endmodule
